>>> rtl/ics_pkg.sv
// shared types and codes for the indexed cv pair access sequencer
`timescale 1ns / 1ps
package ics_pkg;

  localparam int unsigned RetryW = 4;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_CONFIRM = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRI  = 2'd1,
    PH_SEC  = 2'd2,
    PH_ACC  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_CONFIRM = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CMD_PRI     = 3'd0,
    CMD_SEC     = 3'd1,
    CMD_READ    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_CONFIRM = 3'd4,
    CMD_NONE    = 3'd5
  } cmd_t;

  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SAME   = 3'd2;
  localparam logic [2:0] ST_DIFF   = 3'd3;

  localparam logic [1:0] REG_UPPER_FIRST = 2'd0;
  localparam logic [1:0] REG_LOW_SEC     = 2'd1;
  localparam logic [1:0] REG_HIGH_SEC    = 2'd2;

  typedef struct packed {
    logic upper_first;
    logic low_uses_secondary;
    logic high_uses_secondary;
  } cfg_t;

  typedef struct packed {
    cmd_t command;
    logic target_high;
    logic busy_res;
    logic finished;
    logic marked_stored;
    logic differs;
  } result_t;

endpackage

>>> rtl/indexed_cv_pair_access_sequencer.sv
// top level of the indexed cv pair access sequencer
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one input beat per cycle, held off only while a result beat stalls
// the state update for each beat is combinational next-state logic fed by the sequencer registers
// reset: synchronous active-high rst returns to idle and restores register defaults
// config port is always ready
`timescale 1ns / 1ps
module indexed_cv_pair_access_sequencer #(
  parameter int unsigned RETRY_LIMIT = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [2:0] completion_status, [7:3] zero
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] command, [3] target_high, [4] busy_res,
                                // [5] marked_stored, [6] differs, [7] zero
  output logic       m_tlast,   // finished
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);
  import ics_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    accept;
  logic    out_ready;

  assign cfg_ready = 1'b1;
  assign s_tready  = out_ready;
  assign accept    = s_tvalid && out_ready;

  ics_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ics_core #(
    .RETRY_LIMIT (RETRY_LIMIT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (s_tuser),
    .status (s_tdata[2:0]),
    .cfg    (cfg),
    .result (result)
  );

  ics_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .ready    (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/ics_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps
module ics_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic          wr_data,
  output ics_pkg::cfg_t cfg
);
  import ics_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upper_first         <= 1'b0;
      cfg.low_uses_secondary  <= 1'b1;
      cfg.high_uses_secondary <= 1'b1;
    end else if (wr_en) begin
      if (wr_index == REG_UPPER_FIRST) cfg.upper_first <= wr_data;
      if (wr_index == REG_LOW_SEC) cfg.low_uses_secondary <= wr_data;
      if (wr_index == REG_HIGH_SEC) cfg.high_uses_secondary <= wr_data;
    end
  end

endmodule

>>> rtl/ics_core.sv
// sequencer state and combinational next-state logic
`timescale 1ns / 1ps
module ics_core #(
  parameter int unsigned RETRY_LIMIT = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       kind,
  input  logic [2:0]       status,
  input  ics_pkg::cfg_t    cfg,
  output ics_pkg::result_t result
);
  import ics_pkg::*;

  localparam logic [RetryW-1:0] RetryLim = RetryW'(RETRY_LIMIT);

  phase_t            phase, phase_next;
  op_t               operation, operation_next;
  logic              on_high_cv, on_high_cv_next;
  logic              second_pass, second_pass_next;
  logic [RetryW-1:0] retry_count, retry_count_next;
  logic              diff_seen, diff_seen_next;

  logic status_ok;
  logic uses_sec;
  cmd_t access_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      operation   <= OP_READ;
      on_high_cv  <= 1'b0;
      second_pass <= 1'b0;
      retry_count <= '0;
      diff_seen   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      operation   <= operation_next;
      on_high_cv  <= on_high_cv_next;
      second_pass <= second_pass_next;
      retry_count <= retry_count_next;
      diff_seen   <= diff_seen_next;
    end
  end

  always_comb begin
    unique case (operation)
      OP_WRITE:   access_cmd = CMD_WRITE;
      OP_CONFIRM: access_cmd = CMD_CONFIRM;
      default:    access_cmd = CMD_READ;
    endcase
  end

  always_comb begin
    status_ok = (status == ST_STORED);
    if (phase == PH_ACC) begin
      unique case (operation)
        OP_READ:    status_ok = (status == ST_READ);
        OP_CONFIRM: status_ok = (status == ST_SAME) || (status == ST_DIFF);
        default:    status_ok = (status == ST_STORED);
      endcase
    end
  end

  assign uses_sec = on_high_cv ? cfg.high_uses_secondary : cfg.low_uses_secondary;

  always_comb begin
    phase_next       = phase;
    operation_next   = operation;
    on_high_cv_next  = on_high_cv;
    second_pass_next = second_pass;
    retry_count_next = retry_count;
    diff_seen_next   = diff_seen;
    result.command       = CMD_NONE;
    result.target_high   = 1'b0;
    result.finished      = 1'b0;
    result.marked_stored = 1'b0;
    result.differs       = 1'b0;

    if (kind != KIND_DONE) begin
      // start, or restart while busy
      operation_next     = op_t'(kind);
      on_high_cv_next    = cfg.upper_first;
      second_pass_next   = 1'b0;
      retry_count_next   = '0;
      diff_seen_next     = 1'b0;
      phase_next         = PH_PRI;
      result.command     = CMD_PRI;
      result.target_high = cfg.upper_first;
    end else if (phase != PH_IDLE) begin
      result.target_high = on_high_cv;
      if (!status_ok && (retry_count < RetryLim)) begin
        // reissue the same command
        retry_count_next = retry_count + RetryW'(1);
        unique case (phase)
          PH_PRI:  result.command = CMD_PRI;
          PH_SEC:  result.command = CMD_SEC;
          default: result.command = access_cmd;
        endcase
      end else begin
        retry_count_next = '0;
        unique case (phase)
          PH_PRI: begin
            if (uses_sec) begin
              phase_next     = PH_SEC;
              result.command = CMD_SEC;
            end else begin
              phase_next     = PH_ACC;
              result.command = access_cmd;
            end
          end
          PH_SEC: begin
            phase_next     = PH_ACC;
            result.command = access_cmd;
          end
          default: begin
            if (operation == OP_CONFIRM && status == ST_DIFF) diff_seen_next = 1'b1;
            if (!second_pass) begin
              second_pass_next   = 1'b1;
              on_high_cv_next    = !on_high_cv;
              phase_next         = PH_PRI;
              result.command     = CMD_PRI;
              result.target_high = !on_high_cv;
            end else begin
              phase_next           = PH_IDLE;
              result.target_high   = 1'b0;
              result.finished      = 1'b1;
              result.marked_stored = (operation == OP_WRITE);
              result.differs       = (operation == OP_CONFIRM) && diff_seen_next;
            end
          end
        endcase
      end
    end

    result.busy_res = (phase_next != PH_IDLE);
  end

endmodule

>>> rtl/ics_out_reg.sv
// output register holding one result beat
`timescale 1ns / 1ps
module ics_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ics_pkg::result_t result,
  output logic             ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);
  import ics_pkg::*;

  result_t held;

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= result;
    end
  end

  assign m_tdata = {1'b0, held.differs, held.marked_stored, held.busy_res,
                    held.target_high, held.command};
  assign m_tlast = held.finished;

endmodule

>>> rtl/ics_checker.sv
// port-level checker bound to the sequencer top level
`timescale 1ns / 1ps
module ics_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import ics_pkg::*;

  // an accepted beat always yields a result beat in the next cycle
  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted beat produced no result");

  // finishing ends the sequence with no command issued
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[2:0] == CMD_NONE) && !m_tdata[4])
    else $error("finish beat with a command or still busy");

  // stored and differs flags only on a finishing beat, and never both together
  a_flags_on_finish: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5] || m_tdata[6]) |-> m_tlast && !(m_tdata[5] && m_tdata[6]))
    else $error("result flags outside a finish beat");

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

endmodule

bind indexed_cv_pair_access_sequencer ics_checker u_ics_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> sim/ics_sequence_checker.sv
// checker for the indexed cv pair access sequencer: predicts each result beat and compares
`timescale 1ns / 1ps
module ics_sequence_checker
  import ics_pkg::*;
#(
  parameter int unsigned RETRY_LIMIT = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  output int unsigned errors,
  output int unsigned waiting
);

  cfg_t              cfg;
  phase_t            ph;
  op_t               op;
  logic              on_high;
  logic              second_pass;
  logic [RetryW-1:0] retries;
  logic              diff_seen;
  result_t           expected_results[$];
  int unsigned       fails = 0;

  initial begin
    errors  = 0;
    waiting = 0;
  end

  function automatic logic status_good(logic [2:0] st);
    if (ph == PH_ACC && op == OP_READ) return st == ST_READ;
    if (ph == PH_ACC && op == OP_CONFIRM) return st == ST_SAME || st == ST_DIFF;
    return st == ST_STORED;
  endfunction

  function automatic cmd_t current_cmd();
    case (ph)
      PH_PRI: return CMD_PRI;
      PH_SEC: return CMD_SEC;
      default: begin
        case (op)
          OP_READ:  return CMD_READ;
          OP_WRITE: return CMD_WRITE;
          default:  return CMD_CONFIRM;
        endcase
      end
    endcase
  endfunction

  function automatic result_t advance_sequence(kind_t k, logic [2:0] st);
    result_t r;
    r = '0;
    r.command = CMD_NONE;
    if (k != KIND_DONE) begin
      // start, or restart from the top while busy
      op          = op_t'(k);
      on_high     = cfg.upper_first;
      second_pass = 1'b0;
      retries     = '0;
      diff_seen   = 1'b0;
      ph          = PH_PRI;
      r.command   = CMD_PRI;
      r.target_high = on_high;
    end else if (ph != PH_IDLE) begin
      if (!status_good(st) && retries < RETRY_LIMIT) begin
        retries = retries + RetryW'(1);
        r.command = current_cmd();
        r.target_high = on_high;
      end else begin
        // success, or retries used up: move on either way
        retries = '0;
        case (ph)
          PH_PRI: begin
            ph = (on_high ? cfg.high_uses_secondary : cfg.low_uses_secondary) ? PH_SEC : PH_ACC;
            r.command = current_cmd();
            r.target_high = on_high;
          end
          PH_SEC: begin
            ph = PH_ACC;
            r.command = current_cmd();
            r.target_high = on_high;
          end
          default: begin
            if (op == OP_CONFIRM && st == ST_DIFF) diff_seen = 1'b1;
            if (!second_pass) begin
              second_pass = 1'b1;
              on_high = !on_high;
              ph = PH_PRI;
              r.command = CMD_PRI;
              r.target_high = on_high;
            end else begin
              ph = PH_IDLE;
              r.finished = 1'b1;
              r.marked_stored = (op == OP_WRITE);
              r.differs = (op == OP_CONFIRM) && diff_seen;
            end
          end
        endcase
      end
    end
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  function automatic int unsigned check_field(string name, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg = '{upper_first: 1'b0, low_uses_secondary: 1'b1, high_uses_secondary: 1'b1};
      ph = PH_IDLE;
      op = OP_READ;
      on_high = 1'b0;
      second_pass = 1'b0;
      retries = '0;
      diff_seen = 1'b0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, expected none, got data %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_results.pop_front();
          fails += check_field("command", want.command, m_tdata[2:0]);
          fails += check_field("target_high", want.target_high, m_tdata[3]);
          fails += check_field("busy_res", want.busy_res, m_tdata[4]);
          fails += check_field("finished", want.finished, m_tlast);
          fails += check_field("marked_stored", want.marked_stored, m_tdata[5]);
          fails += check_field("differs", want.differs, m_tdata[6]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UPPER_FIRST: cfg.upper_first = cfg_data;
          REG_LOW_SEC:     cfg.low_uses_secondary = cfg_data;
          REG_HIGH_SEC:    cfg.high_uses_secondary = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(advance_sequence(kind_t'(s_tuser), s_tdata[2:0]));
    end
    errors  <= fails;
    waiting <= expected_results.size();
  end

endmodule

>>> sim/tb_top.sv
// testbench top for the indexed cv pair access sequencer: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
  import ics_pkg::*;

  localparam int unsigned RETRY_LIMIT    = 2;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned PHASE_ITEMS    = 90;
  localparam int unsigned WATCHDOG_LIMIT = 400;

  localparam logic [2:0] ST_FAILED = 3'd4;
  localparam logic [2:0] ST_BOGUS  = 3'd5;
  localparam logic [2:0] ST_TOP    = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic [1:0] s_tuser = KIND_READ;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_UPPER_FIRST;
  logic       cfg_data = 1'b0;

  int unsigned errors;
  int unsigned open_results;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned finishes_seen = 0;
  int unsigned idle_hits = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  always #5 clk = ~clk;

  indexed_cv_pair_access_sequencer #(.RETRY_LIMIT(RETRY_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ics_sequence_checker #(.RETRY_LIMIT(RETRY_LIMIT)) seq_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .waiting(open_results)
  );

  task automatic send_beat(kind_t k, logic [2:0] st);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {5'd0, st};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
    @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(cfg_t c);
    put_reg(REG_UPPER_FIRST, c.upper_first);
    put_reg(REG_LOW_SEC, c.low_uses_secondary);
    put_reg(REG_HIGH_SEC, c.high_uses_secondary);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly the status each step wants, sometimes anything the field holds
  function automatic logic [2:0] pick_status(op_t op);
    int unsigned roll;
    logic [2:0] any_st;
    roll = $urandom_range(0, 99);
    any_st = 3'($urandom_range(0, 7));
    if (roll < 15) return any_st;
    case (op)
      OP_READ:  return (roll < 55) ? ST_STORED : ST_READ;
      OP_WRITE: return ST_STORED;
      default:  return (roll < 55) ? ST_STORED : ((roll < 78) ? ST_SAME : ST_DIFF);
    endcase
  endfunction

  task automatic run_sequence();
    op_t op;
    int unsigned n;
    op = op_t'($urandom_range(0, 2));
    send_beat(kind_t'(op), 3'($urandom_range(0, 7)));
    n = $urandom_range(4, 16);
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 3);
    repeat (n) send_beat(KIND_DONE, pick_status(op));
  endtask

  // result side: random stall before each beat
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_steady ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      if (m_tlast) finishes_seen++;
      if (m_tdata[2:0] == CMD_NONE && !m_tlast) idle_hits++;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", idle_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t        setting;
    logic [2:0]  bits;
    int unsigned p;
    int unsigned quota;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // completion while idle is ignored
    send_beat(KIND_DONE, ST_STORED);
    // clean read over both cvs, secondary index on both
    send_beat(KIND_READ, ST_TOP);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_READ);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_READ);
    // write with retries, one command running out of retries
    send_beat(KIND_WRITE, ST_STORED);
    send_beat(KIND_DONE, ST_FAILED);
    send_beat(KIND_DONE, ST_TOP);
    send_beat(KIND_DONE, ST_READ);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_BOGUS);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    // restart while busy
    send_beat(KIND_CONFIRM, ST_FAILED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_CONFIRM, ST_SAME);
    // high cv first, no secondary index, confirm that sees a difference
    settle();
    setting = '{upper_first: 1'b1, low_uses_secondary: 1'b0, high_uses_secondary: 1'b0};
    apply_settings(setting);
    send_beat(KIND_CONFIRM, ST_STORED);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_DIFF);
    send_beat(KIND_DONE, ST_STORED);
    send_beat(KIND_DONE, ST_SAME);

    p = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      if (p < 8) bits = p[2:0];
      else bits = 3'($urandom_range(0, 7));
      setting = bits;
      apply_settings(setting);
      send_steady = (p % 3 == 1);
      recv_steady = (p % 4 == 2);
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota && items_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 19) == 0) send_beat(KIND_DONE, 3'($urandom_range(0, 7)));
        run_sequence();
      end
      p++;
    end
    settle();
    repeat (3) @(posedge clk);

    $display("run covered %0d input beats, %0d result beats, %0d finished sequences",
             items_sent, results_seen, finishes_seen);
    $display("over %0d register settings, %0d completions ignored while idle",
             settings_used, idle_hits);
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> indexed_cv_pair_access_sequencer.f
rtl/ics_pkg.sv
rtl/ics_cfg_regs.sv
rtl/ics_core.sv
rtl/ics_out_reg.sv
rtl/indexed_cv_pair_access_sequencer.sv
rtl/ics_checker.sv
sim/ics_sequence_checker.sv
sim/tb_top.sv
